### design/pst_pkg.sv
package pst_pkg;

  // Fixed framing constants of the TS and PES formats.
  localparam int PES_OVERHEAD        = 14;
  localparam int FIRST_PAYLOAD_BYTES = 164;
  localparam logic [12:0] PID_RESET  = 13'h1100;

  localparam logic [7:0]  TS_PAYLOAD_BYTES = 8'd184;
  localparam logic [1:0]  ADAPT_PAYLOAD_ONLY = 2'd1;
  localparam logic [1:0]  ADAPT_BOTH         = 2'd3;

  typedef enum logic [2:0] {
    VERDICT_IGNORED  = 3'd0,
    VERDICT_APPENDED = 3'd1,
    VERDICT_COMPLETE = 3'd2,
    VERDICT_GAP_DROP = 3'd3,
    VERDICT_OVF_DROP = 3'd4
  } verdict_t;

  typedef enum logic {
    ST_SEARCH  = 1'b0,
    ST_COLLECT = 1'b1
  } slice_state_t;

  // One pre-parsed TS header beat.
  typedef struct packed {
    logic [15:0] rtp_sequence;
    logic        packet_first;
    logic        packet_last;
    logic        unit_start;
    logic [12:0] stream_tag;
    logic [1:0]  adapt_control;
    logic [7:0]  adapt_length;
    logic [15:0] pes_length_field;
  } item_t;

  // Summary of one whole RTP packet, handed from front to back.
  typedef struct packed {
    logic [15:0] seq;
    logic [15:0] byte_sum;
    logic        start_seen;
    logic [15:0] start_length;
  } pkt_rec_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [16:0] bytes_collected;
    logic [15:0] bytes_expected;
    logic [15:0] packet_sequence;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

### design/pst_fifo.sv
module pst_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output pst_pkg::fifo_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_data    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_wr, do_rd})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      2'b11:   cnt_nxt = cnt_r;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### design/pst_front.sv
module pst_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [12:0]       cfg_wr_data,
  input  logic              accept,
  input  pst_pkg::item_t    item,
  output logic              rec_push,
  output pst_pkg::pkt_rec_t rec
);

  logic [12:0] pid_r;
  logic [15:0] sum_r, sum_nxt;
  logic        seen_r, seen_nxt;
  logic [15:0] len_r, len_nxt;

  logic [7:0]  payload;
  logic [15:0] sum_base;
  logic        seen_base;
  logic [15:0] len_base;
  logic [16:0] sum_ext;
  logic [15:0] sum_item;
  logic        seen_item;
  logic [15:0] len_item;
  logic        on_pid;

  assign on_pid = (item.stream_tag == pid_r);

  always_comb begin
    if (item.unit_start) begin
      payload = 8'(pst_pkg::FIRST_PAYLOAD_BYTES);
    end else if (item.adapt_control == pst_pkg::ADAPT_PAYLOAD_ONLY) begin
      payload = pst_pkg::TS_PAYLOAD_BYTES;
    end else if (item.adapt_control == pst_pkg::ADAPT_BOTH) begin
      // An adaptation field longer than the packet leaves no payload.
      payload = (item.adapt_length > pst_pkg::TS_PAYLOAD_BYTES - 8'd1) ? 8'd0 :
                (pst_pkg::TS_PAYLOAD_BYTES - 8'd1 - item.adapt_length);
    end else begin
      payload = 8'd0;
    end
  end

  always_comb begin
    sum_base  = item.packet_first ? 16'd0 : sum_r;
    seen_base = item.packet_first ? 1'b0  : seen_r;
    len_base  = item.packet_first ? 16'd0 : len_r;
    sum_ext   = {1'b0, sum_base} + {9'd0, payload};
    sum_item  = sum_base;
    seen_item = seen_base;
    len_item  = len_base;
    if (on_pid) begin
      sum_item = sum_ext[16] ? 16'hFFFF : sum_ext[15:0];
      if (item.unit_start && !seen_base) begin
        seen_item = 1'b1;
        len_item  = item.pes_length_field;
      end
    end
    if (item.packet_last) begin
      sum_nxt  = 16'd0;
      seen_nxt = 1'b0;
      len_nxt  = 16'd0;
    end else begin
      sum_nxt  = sum_item;
      seen_nxt = seen_item;
      len_nxt  = len_item;
    end
  end

  assign rec_push         = accept && item.packet_last;
  assign rec.seq          = item.rtp_sequence;
  assign rec.byte_sum     = sum_item;
  assign rec.start_seen   = seen_item;
  assign rec.start_length = len_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pid_r  <= pst_pkg::PID_RESET;
      sum_r  <= '0;
      seen_r <= 1'b0;
      len_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        pid_r <= cfg_wr_data;
      end
      if (accept) begin
        sum_r  <= sum_nxt;
        seen_r <= seen_nxt;
        len_r  <= len_nxt;
      end
    end
  end

endmodule

### design/pst_back.sv
module pst_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rec_valid,
  input  pst_pkg::pkt_rec_t rec,
  input  logic              res_room,
  output logic              rec_pop,
  output logic              res_push,
  output pst_pkg::result_t  res
);

  pst_pkg::slice_state_t state_r, state_nxt;
  logic [15:0] last_seq_r;
  logic [16:0] count_r;
  logic [15:0] expected_r;
  logic        unbounded_r;

  logic        opening, active, gap, short_len;
  logic        eff_unbounded;
  logic [15:0] eff_expected;
  logic [16:0] eff_count;
  logic [17:0] count_ext;
  logic [16:0] count_sat;
  logic        over, equal;

  assign rec_pop  = rec_valid && res_room;
  assign res_push = rec_pop;

  always_comb begin
    opening       = (state_r == pst_pkg::ST_SEARCH) && rec.start_seen;
    active        = opening || (state_r == pst_pkg::ST_COLLECT);
    short_len     = rec.start_length < 16'(pst_pkg::PES_OVERHEAD);
    eff_unbounded = opening ? short_len : unbounded_r;
    eff_expected  = opening ? (short_len ? 16'd0 :
                               rec.start_length - 16'(pst_pkg::PES_OVERHEAD))
                            : expected_r;
    eff_count     = opening ? 17'd0 : count_r;
    // A freshly opened slice always sees its own sequence as the next one.
    gap           = (state_r == pst_pkg::ST_COLLECT) &&
                    (rec.seq != 16'(last_seq_r + 16'd1));
    count_ext     = {1'b0, eff_count} + {2'b0, rec.byte_sum};
    count_sat     = count_ext[17] ? 17'h1FFFF : count_ext[16:0];
    over          = count_sat > {1'b0, eff_expected};
    equal         = count_sat == {1'b0, eff_expected};
  end

  // Next state of the slice tracker.
  always_comb begin
    state_nxt = state_r;
    if (rec_pop && active) begin
      if (gap) begin
        state_nxt = pst_pkg::ST_SEARCH;
      end else if (!eff_unbounded && (over || equal)) begin
        state_nxt = pst_pkg::ST_SEARCH;
      end else begin
        state_nxt = pst_pkg::ST_COLLECT;
      end
    end
  end

  // Verdict for the packet being retired.
  always_comb begin
    res.packet_sequence = rec.seq;
    res.verdict         = pst_pkg::VERDICT_IGNORED;
    res.bytes_collected = 17'd0;
    res.bytes_expected  = 16'd0;
    if (active) begin
      res.bytes_expected = eff_expected;
      if (gap) begin
        res.verdict         = pst_pkg::VERDICT_GAP_DROP;
        res.bytes_collected = eff_count;
      end else begin
        res.bytes_collected = count_sat;
        if (eff_unbounded) begin
          res.verdict = pst_pkg::VERDICT_APPENDED;
        end else if (over) begin
          res.verdict = pst_pkg::VERDICT_OVF_DROP;
        end else if (equal) begin
          res.verdict = pst_pkg::VERDICT_COMPLETE;
        end else begin
          res.verdict = pst_pkg::VERDICT_APPENDED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pst_pkg::ST_SEARCH;
      last_seq_r  <= '0;
      count_r     <= '0;
      expected_r  <= '0;
      unbounded_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (rec_pop && active) begin
        if (opening) begin
          expected_r  <= eff_expected;
          unbounded_r <= eff_unbounded;
        end
        if (!gap) begin
          last_seq_r <= rec.seq;
          count_r    <= count_sat;
        end
      end
    end
  end

endmodule

### design/pes_slice_reassembly_tracker.sv
// Channel  Direction  Handshake             Beat carries
// in_      input      push / full           one pre-parsed TS header and its RTP sequence
// out_     output     empty / pop           one verdict per RTP packet
// cfg_     input      cfg_wr_en             audio stream PID, 13 bits
//
// One input beat is accepted every cycle while full is low; the rate is set by the
// front accumulator, which folds one TS header per cycle into the packet sum.
// A verdict reaches the out_ ports through the packet queue and then the result queue
// once its packet's last beat is accepted; it waits there while the result queue is full.
// Synchronous active-low reset empties both queues, clears all tracking and sets PID 0x1100.
// full rises only when the packet queue is full, so a stalled consumer backs up
// through the result queue and the packet queue before the input side stalls.
module pes_slice_reassembly_tracker #(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        push,
  output logic        full,
  input  logic [15:0] in_rtp_sequence,
  input  logic        in_packet_first,
  input  logic        in_packet_last,
  input  logic        in_unit_start,
  input  logic [12:0] in_stream_tag,
  input  logic [1:0]  in_adapt_control,
  input  logic [7:0]  in_adapt_length,
  input  logic [15:0] in_pes_length_field,
  // Result channel.
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_verdict,
  output logic [16:0] out_bytes_collected,
  output logic [15:0] out_bytes_expected,
  output logic [15:0] out_packet_sequence,
  // Configuration.
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data
);

  pst_pkg::item_t      item;
  pst_pkg::pkt_rec_t   rec_in, rec_out;
  pst_pkg::result_t    res_in, res_out;
  pst_pkg::fifo_stat_t mid_stat, out_stat;
  logic                accept, rec_push, rec_pop, res_push;

  assign item.rtp_sequence     = in_rtp_sequence;
  assign item.packet_first     = in_packet_first;
  assign item.packet_last      = in_packet_last;
  assign item.unit_start       = in_unit_start;
  assign item.stream_tag       = in_stream_tag;
  assign item.adapt_control    = in_adapt_control;
  assign item.adapt_length     = in_adapt_length;
  assign item.pes_length_field = in_pes_length_field;

  // The input side stalls only on a full packet queue; beats that do not close
  // a packet never need a slot, but holding them too keeps the handshake simple.
  assign full   = mid_stat.full;
  assign accept = push && !full;

  // Front: per-beat payload accounting for the current RTP packet.
  pst_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .item        (item),
    .rec_push    (rec_push),
    .rec         (rec_in)
  );

  // Packet queue decoupling the accumulator from the slice tracker.
  pst_fifo #(
    .WIDTH ($bits(pst_pkg::pkt_rec_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (rec_push),
    .wr_data (rec_in),
    .rd_en   (rec_pop),
    .rd_data (rec_out),
    .stat    (mid_stat)
  );

  // Back: slice state machine, one packet per cycle while the result queue has room.
  pst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (!mid_stat.empty),
    .rec       (rec_out),
    .res_room  (!out_stat.full),
    .rec_pop   (rec_pop),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Result queue; its head drives the out_ ports directly.
  pst_fifo #(
    .WIDTH ($bits(pst_pkg::result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_in),
    .rd_en   (pop),
    .rd_data (res_out),
    .stat    (out_stat)
  );

  assign empty               = out_stat.empty;
  assign out_verdict         = res_out.verdict;
  assign out_bytes_collected = res_out.bytes_collected;
  assign out_bytes_expected  = res_out.bytes_expected;
  assign out_packet_sequence = res_out.packet_sequence;

endmodule

### design/pst_checker.sv
module pst_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  out_verdict,
  input logic [16:0] out_bytes_collected,
  input logic [15:0] out_bytes_expected,
  input logic [15:0] out_packet_sequence
);

  // Reset leaves both queues empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

  // A waiting verdict is held until it is popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_verdict) &&
                          $stable(out_bytes_collected) &&
                          $stable(out_packet_sequence)))
    else $error("stalled verdict changed");

  // An ignored packet reports no slice figures.
  a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_verdict == pst_pkg::VERDICT_IGNORED) |->
      (out_bytes_collected == 17'd0 && out_bytes_expected == 16'd0))
    else $error("ignored packet shows slice figures");

  // A completed slice has collected exactly what it expected.
  a_complete_match: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_verdict == pst_pkg::VERDICT_COMPLETE) |->
      (out_bytes_collected == {1'b0, out_bytes_expected}))
    else $error("complete verdict with mismatched count");

  // An overflow drop has collected more than it expected.
  a_overflow_more: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_verdict == pst_pkg::VERDICT_OVF_DROP) |->
      (out_bytes_collected > {1'b0, out_bytes_expected}))
    else $error("overflow verdict without excess bytes");

endmodule

bind pes_slice_reassembly_tracker pst_checker u_pst_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .full                (full),
  .empty               (empty),
  .pop                 (pop),
  .out_verdict         (out_verdict),
  .out_bytes_collected (out_bytes_collected),
  .out_bytes_expected  (out_bytes_expected),
  .out_packet_sequence (out_packet_sequence)
);

### verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The watchdog gives up after this many cycles in which no beat moves on either side.
  // The longest deliberate receiver hold-off is HOLD_OFF_CYCLES, so this leaves ample margin.
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 120;
  // A verdict passes through the packet queue and the result queue before it can be popped; settle for longer.
  localparam int SETTLE_CYCLES   = 8;
  localparam int PHASE_BEATS     = 75;
  localparam int PRINT_CAP       = 40;

  typedef enum int {
    PRESS_NONE,
    PRESS_HOLD_OFF,
    PRESS_DRAIN
  } pressure_t;

  // One row of the directed table. Where typed is set, the verdict is written in by hand.
  typedef struct {
    pst_pkg::item_t   beat;
    bit               typed;
    pst_pkg::result_t verdict_row;
  } dir_row_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           push = 1'b0;
  logic           full;
  pst_pkg::item_t in_beat = '0;
  logic           empty;
  logic           pop = 1'b0;
  logic [2:0]     out_verdict;
  logic [16:0]    out_bytes_collected;
  logic [15:0]    out_bytes_expected;
  logic [15:0]    out_packet_sequence;
  logic           cfg_wr_en = 1'b0;
  logic [12:0]    cfg_wr_data = '0;

  // Shaping of the traffic, set per phase by the stimulus process.
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_off_req = 1'b0;
  int          hold_off_left = 0;

  int          mismatch_count = 0;
  int          beats_on_pid = 0;
  logic [15:0] next_seq;

  // Verdicts that the tracker owes us, oldest first.
  pst_pkg::result_t verdicts_due[$];
  dir_row_t         dir_rows[$];

  // Own copy of the tracker: configuration, slice state and the running packet summary.
  logic [12:0]           pid_reg = pst_pkg::PID_RESET;
  pst_pkg::slice_state_t trk_state = pst_pkg::ST_SEARCH;
  logic [15:0]           trk_last_seq = '0;
  logic [16:0]           trk_count = '0;
  logic [15:0]           trk_expected = '0;
  logic                  trk_unbounded = 1'b0;
  logic [15:0]           pkt_sum = '0;
  logic                  pkt_start_seen = 1'b0;
  logic [15:0]           pkt_start_len = '0;

  always #6 clk = ~clk;

  pes_slice_reassembly_tracker u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .in_rtp_sequence     (in_beat.rtp_sequence),
    .in_packet_first     (in_beat.packet_first),
    .in_packet_last      (in_beat.packet_last),
    .in_unit_start       (in_beat.unit_start),
    .in_stream_tag       (in_beat.stream_tag),
    .in_adapt_control    (in_beat.adapt_control),
    .in_adapt_length     (in_beat.adapt_length),
    .in_pes_length_field (in_beat.pes_length_field),
    .empty               (empty),
    .pop                 (pop),
    .out_verdict         (out_verdict),
    .out_bytes_collected (out_bytes_collected),
    .out_bytes_expected  (out_bytes_expected),
    .out_packet_sequence (out_packet_sequence),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  // Folds one accepted TS header into the packet summary. On the last beat of a packet it
  // settles the slice and returns 1 with the verdict for the whole packet.
  function automatic bit track_beat(input pst_pkg::item_t it, output pst_pkg::result_t res);
    int          payload;
    int          sum;
    logic [15:0] seq_wanted;
    res = '0;
    if (it.packet_first) begin
      pkt_sum        = '0;
      pkt_start_seen = 1'b0;
      pkt_start_len  = '0;
    end
    if (it.stream_tag == pid_reg) begin
      // A unit start always carries the fixed first payload, whatever the control says.
      if (it.unit_start) begin
        payload = pst_pkg::FIRST_PAYLOAD_BYTES;
      end else if (it.adapt_control == pst_pkg::ADAPT_PAYLOAD_ONLY) begin
        payload = int'(pst_pkg::TS_PAYLOAD_BYTES);
      end else if (it.adapt_control == pst_pkg::ADAPT_BOTH) begin
        // An adaptation field that claims the whole packet leaves no payload at all.
        if (int'(it.adapt_length) > int'(pst_pkg::TS_PAYLOAD_BYTES) - 1) begin
          payload = 0;
        end else begin
          payload = int'(pst_pkg::TS_PAYLOAD_BYTES) - 1 - int'(it.adapt_length);
        end
      end else begin
        payload = 0;
      end
      sum = int'(pkt_sum) + payload;
      pkt_sum = (sum > 65535) ? 16'hFFFF : sum[15:0];
      // Only the first unit start on the stream within a packet gives the PES length.
      if (it.unit_start && !pkt_start_seen) begin
        pkt_start_seen = 1'b1;
        pkt_start_len  = it.pes_length_field;
      end
    end
    if (!it.packet_last) begin
      return 1'b0;
    end
    if (trk_state == pst_pkg::ST_SEARCH && pkt_start_seen) begin
      trk_state = pst_pkg::ST_COLLECT;
      trk_count = '0;
      // A PES length shorter than the header leaves a slice that can never finish.
      if (int'(pkt_start_len) < pst_pkg::PES_OVERHEAD) begin
        trk_unbounded = 1'b1;
        trk_expected  = '0;
      end else begin
        trk_unbounded = 1'b0;
        trk_expected  = pkt_start_len - 16'(pst_pkg::PES_OVERHEAD);
      end
      trk_last_seq = it.rtp_sequence - 16'd1;
    end
    res.verdict         = pst_pkg::VERDICT_IGNORED;
    res.packet_sequence = it.rtp_sequence;
    if (trk_state == pst_pkg::ST_COLLECT) begin
      res.bytes_expected = trk_expected;
      seq_wanted = trk_last_seq + 16'd1;
      if (it.rtp_sequence != seq_wanted) begin
        // On a gap the count shown is the one held before this packet.
        res.verdict         = pst_pkg::VERDICT_GAP_DROP;
        res.bytes_collected = trk_count;
        trk_state           = pst_pkg::ST_SEARCH;
      end else begin
        sum = int'(trk_count) + int'(pkt_sum);
        trk_last_seq = it.rtp_sequence;
        trk_count    = (sum > 131071) ? 17'h1FFFF : sum[16:0];
        res.bytes_collected = trk_count;
        if (trk_unbounded) begin
          res.verdict = pst_pkg::VERDICT_APPENDED;
        end else if (trk_count > {1'b0, trk_expected}) begin
          res.verdict = pst_pkg::VERDICT_OVF_DROP;
          trk_state   = pst_pkg::ST_SEARCH;
        end else if (trk_count == {1'b0, trk_expected}) begin
          res.verdict = pst_pkg::VERDICT_COMPLETE;
          trk_state   = pst_pkg::ST_SEARCH;
        end else begin
          res.verdict = pst_pkg::VERDICT_APPENDED;
        end
      end
    end
    pkt_sum        = '0;
    pkt_start_seen = 1'b0;
    pkt_start_len  = '0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_CAP) begin
      $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  function automatic void add_row(input logic [15:0] seq, input bit first, input bit last,
                                  input bit start, input logic [12:0] pid,
                                  input logic [1:0] ctrl, input logic [7:0] alen,
                                  input logic [15:0] plen, input bit typed,
                                  input pst_pkg::verdict_t v, input int coll, input int expd);
    dir_row_t row;
    row.beat.rtp_sequence     = seq;
    row.beat.packet_first     = first;
    row.beat.packet_last      = last;
    row.beat.unit_start       = start;
    row.beat.stream_tag       = pid;
    row.beat.adapt_control    = ctrl;
    row.beat.adapt_length     = alen;
    row.beat.pes_length_field = plen;
    row.typed                 = typed;
    row.verdict_row.verdict         = v;
    row.verdict_row.bytes_collected = coll[16:0];
    row.verdict_row.bytes_expected  = expd[15:0];
    row.verdict_row.packet_sequence = seq;
    dir_rows.push_back(row);
  endfunction

  // Offers one beat, entered and left at a falling edge. Before the beat the sender may sit
  // idle while a random draw falls below send_idle_pct; push is only ever assigned once per falling edge.
  task automatic send_beat(input pst_pkg::item_t it, input bit typed,
                           input pst_pkg::result_t typed_res);
    pst_pkg::result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
      @(negedge clk);
    end
    push    <= 1'b1;
    in_beat <= it;
    do begin
      @(posedge clk);
    end while (full);
    if (track_beat(it, res)) begin
      verdicts_due.push_back(typed ? typed_res : res);
    end
    if (it.stream_tag == pid_reg) begin
      beats_on_pid++;
    end
    @(negedge clk);
  endtask

  // Lowers push and waits until every verdict owed has been taken.
  task automatic drain_verdicts();
    push <= 1'b0;
    while (verdicts_due.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // The PID register is only written once the tracker has gone quiet.
  task automatic write_pid(input logic [12:0] value);
    drain_verdicts();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    pid_reg = value;
  endtask

  // Mostly well-formed RTP packets with random content; now and then a stray beat, a jump in
  // sequence or a repeated sequence number to exercise the drop paths.
  task automatic send_random_packet();
    pst_pkg::item_t it;
    logic [63:0]    raw;
    int             n;
    int             pick;
    bit             opening;
    logic [15:0]    plen;
    pick = $urandom_range(99);
    if (pick < 8) begin
      raw = {$urandom, $urandom};
      it  = raw[57:0];
      send_beat(it, 1'b0, '0);
      return;
    end
    pick = $urandom_range(99);
    if (pick < 6) begin
      next_seq = next_seq + 16'($urandom_range(2, 6));
    end else if (pick < 8) begin
      next_seq = 16'($urandom);
    end else if (pick < 10) begin
      next_seq = next_seq - 16'd1;
    end
    n       = $urandom_range(1, 6);
    opening = (trk_state == pst_pkg::ST_SEARCH) && ($urandom_range(3) != 0);
    case ($urandom_range(4))
      0: plen = 16'(pst_pkg::PES_OVERHEAD + pst_pkg::FIRST_PAYLOAD_BYTES +
                    184 * $urandom_range(0, 4));
      1: plen = 16'($urandom);
      2: plen = 16'($urandom_range(pst_pkg::PES_OVERHEAD, 1200));
      3: plen = 16'(pst_pkg::PES_OVERHEAD + $urandom_range(0, 1000));
      default: plen = 16'($urandom_range(0, 20));
    endcase
    for (int k = 0; k < n; k++) begin
      it.rtp_sequence  = next_seq;
      it.packet_first  = (k == 0);
      it.packet_last   = (k == n - 1);
      it.unit_start    = (opening && k == 0) || ($urandom_range(19) == 0);
      it.stream_tag    = ($urandom_range(9) < 8) ? pid_reg : 13'($urandom);
      it.adapt_control = ($urandom_range(9) < 7) ? pst_pkg::ADAPT_PAYLOAD_ONLY :
                                                   2'($urandom_range(3));
      if ($urandom_range(7) == 0) begin
        it.adapt_length = 8'($urandom);
      end else begin
        it.adapt_length = 8'($urandom_range(0, 183));
      end
      it.pes_length_field = (opening && k == 0) ? plen : 16'($urandom);
      send_beat(it, 1'b0, '0);
    end
    next_seq = next_seq + 16'd1;
  endtask

  // A phase of random packets. The pressure argument chooses whether, part way through, the
  // receiver is told to hold off for a long stretch or the sender waits for a full drain.
  task automatic run_random_phase(input pressure_t pressure);
    bit pressed;
    pressed = 1'b0;
    beats_on_pid = 0;
    while (beats_on_pid < PHASE_BEATS) begin
      send_random_packet();
      if (!pressed && pressure == PRESS_HOLD_OFF && beats_on_pid >= 30) begin
        hold_off_req = 1'b1;
        pressed = 1'b1;
      end
      if (!pressed && pressure == PRESS_DRAIN && beats_on_pid >= 50) begin
        drain_verdicts();
        pressed = 1'b1;
      end
    end
  endtask

  // Receiver: decides at each falling edge whether to pop. A hold-off request from the
  // stimulus side is counted down here, in cycles, while the sender keeps offering beats.
  always @(negedge clk) begin
    if (hold_off_req) begin
      hold_off_left = HOLD_OFF_CYCLES;
      hold_off_req  = 1'b0;
    end
    if (hold_off_left > 0) begin
      pop <= 1'b0;
      hold_off_left--;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every verdict taken is checked field by field against the oldest one owed.
  always @(posedge clk) begin
    pst_pkg::result_t want;
    if (rst_n && pop && !empty) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch("unexpected verdict, packet_sequence", 32'(out_packet_sequence),
                        32'd0);
      end else begin
        want = verdicts_due.pop_front();
        if (out_verdict !== want.verdict) begin
          report_mismatch("verdict", 32'(out_verdict), 32'(want.verdict));
        end
        if (out_bytes_collected !== want.bytes_collected) begin
          report_mismatch("bytes_collected", 32'(out_bytes_collected),
                          32'(want.bytes_collected));
        end
        if (out_bytes_expected !== want.bytes_expected) begin
          report_mismatch("bytes_expected", 32'(out_bytes_expected),
                          32'(want.bytes_expected));
        end
        if (out_packet_sequence !== want.packet_sequence) begin
          report_mismatch("packet_sequence", 32'(out_packet_sequence),
                          32'(want.packet_sequence));
        end
      end
    end
  end

  // Watchdog: counts cycles in which no beat is accepted on either side.
  initial begin
    int idle_run;
    idle_run = 0;
    @(posedge rst_n);
    while (idle_run < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    localparam logic [12:0] P = pst_pkg::PID_RESET;
    // Directed part, run with the PID at its reset value.
    // A packet on some other stream straight after reset is simply ignored.
    add_row(16'd5, 1, 1, 0, 13'h0000, 2'd1, 8'd0, 16'd0, 1, pst_pkg::VERDICT_IGNORED, 0, 0);
    // A slice opens on a unit start and completes exactly in the next packet; the last beat
    // of that packet is on another stream and adds nothing.
    add_row(16'd100, 1, 1, 1, P, 2'd1, 8'd0, 16'd362, 1, pst_pkg::VERDICT_APPENDED, 164, 348);
    add_row(16'd101, 1, 0, 0, P, 2'd1, 8'd0, 16'd0, 0, pst_pkg::VERDICT_IGNORED, 0, 0);
    add_row(16'd101, 0, 1, 0, 13'h1FFF, 2'd1, 8'd0, 16'hFFFF, 1,
            pst_pkg::VERDICT_COMPLETE, 348, 348);
    // Opening at the top sequence number, then wrapping to zero. The continuation packet
    // mixes every adaptation control but payload only, and an adaptation length beyond the packet.
    add_row(16'hFFFF, 1, 1, 1, P, 2'd3, 8'd183, 16'd361, 1,
            pst_pkg::VERDICT_APPENDED, 164, 347);
    add_row(16'd0, 1, 0, 0, P, 2'd3, 8'd255, 16'd0, 0, pst_pkg::VERDICT_IGNORED, 0, 0);
    add_row(16'd0, 0, 0, 0, P, 2'd0, 8'd0, 16'd0, 0, pst_pkg::VERDICT_IGNORED, 0, 0);
    add_row(16'd0, 0, 0, 0, P, 2'd2, 8'd0, 16'd0, 0, pst_pkg::VERDICT_IGNORED, 0, 0);
    add_row(16'd0, 0, 0, 0, P, 2'd3, 8'd0, 16'd0, 0, pst_pkg::VERDICT_IGNORED, 0, 0);
    add_row(16'd0, 0, 1, 0, P, 2'd3, 8'd183, 16'd0, 1, pst_pkg::VERDICT_COMPLETE, 347, 347);
    // A sequence gap drops the slice and shows the count from before the packet; the unit
    // start inside the gap packet does not reopen anything.
    add_row(16'd200, 1, 1, 1, P, 2'd1, 8'd0, 16'd1000, 1, pst_pkg::VERDICT_APPENDED, 164, 986);
    add_row(16'd202, 1, 1, 1, P, 2'd1, 8'd0, 16'd500, 1, pst_pkg::VERDICT_GAP_DROP, 164, 986);
    // Overshoot on the opening packet, once with a PES length exactly equal to the header.
    add_row(16'd300, 1, 1, 1, P, 2'd1, 8'd0, 16'd114, 1, pst_pkg::VERDICT_OVF_DROP, 164, 100);
    add_row(16'd301, 1, 1, 1, P, 2'd1, 8'd0, 16'd14, 1, pst_pkg::VERDICT_OVF_DROP, 164, 0);
    // A short PES length gives a slice that only ever appends, until a gap ends it.
    add_row(16'd400, 1, 1, 1, P, 2'd1, 8'd0, 16'd13, 1, pst_pkg::VERDICT_APPENDED, 164, 0);
    add_row(16'd401, 1, 1, 0, P, 2'd1, 8'd0, 16'd0, 1, pst_pkg::VERDICT_APPENDED, 348, 0);
    add_row(16'd403, 1, 1, 0, P, 2'd1, 8'd0, 16'd0, 1, pst_pkg::VERDICT_GAP_DROP, 348, 0);
    // Several unit starts in one packet: the first one on the stream sets the length.
    add_row(16'd500, 1, 0, 1, 13'h0FFF, 2'd1, 8'd0, 16'd50, 0, pst_pkg::VERDICT_IGNORED, 0, 0);
    add_row(16'd500, 0, 0, 1, P, 2'd3, 8'd7, 16'd342, 0, pst_pkg::VERDICT_IGNORED, 0, 0);
    add_row(16'd500, 0, 1, 1, P, 2'd1, 8'd0, 16'd20, 1, pst_pkg::VERDICT_COMPLETE, 328, 328);
    // A packet whose only beat lacks the first flag, then one where the first flag turns up
    // part way through and throws away what came before it.
    add_row(16'd600, 0, 1, 1, P, 2'd1, 8'd0, 16'd0, 1, pst_pkg::VERDICT_APPENDED, 164, 0);
    add_row(16'd601, 0, 0, 0, P, 2'd1, 8'd0, 16'd0, 0, pst_pkg::VERDICT_IGNORED, 0, 0);
    add_row(16'd601, 1, 0, 0, P, 2'd1, 8'd0, 16'd0, 0, pst_pkg::VERDICT_IGNORED, 0, 0);
    add_row(16'd601, 0, 1, 0, P, 2'd2, 8'd0, 16'd0, 0, pst_pkg::VERDICT_IGNORED, 0, 0);
    // Close with a gap and open again with the largest PES length.
    add_row(16'd700, 1, 1, 0, P, 2'd1, 8'd0, 16'd0, 1, pst_pkg::VERDICT_GAP_DROP, 348, 0);
    add_row(16'd701, 1, 1, 1, P, 2'd3, 8'd0, 16'hFFFF, 1,
            pst_pkg::VERDICT_APPENDED, 164, 65521);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].verdict_row);
    end

    next_seq = 16'($urandom);

    // Random phases, each under its own PID and its own idling pattern.
    write_pid(13'h0000);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_phase(PRESS_HOLD_OFF);

    write_pid(13'h1FFF);
    send_idle_pct  = 58;
    recv_stall_pct = 0;
    run_random_phase(PRESS_DRAIN);

    write_pid(13'($urandom_range(1, 8190)));
    send_idle_pct  = 0;
    recv_stall_pct = 58;
    run_random_phase(PRESS_NONE);

    write_pid(pst_pkg::PID_RESET);
    send_idle_pct  = 35;
    recv_stall_pct = 35;
    run_random_phase(PRESS_NONE);

    drain_verdicts();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && verdicts_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
